// ===== sv/bslp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment loader parser package
// Shared widths, codes and the result record of the segment loader parser.
// ----------------------------------------------------------------------------
package bslp_pkg;

   localparam int AddrBits = 16;
   localparam int LenBits  = 16;

   typedef logic [AddrBits-1:0] addr_type;
   typedef logic [LenBits-1:0]  len_type;
   typedef logic [7:0]          byte_type;

   localparam byte_type TypeData = 8'h00;
   localparam byte_type TypeEnd  = 8'hff;

   typedef enum logic [2:0] {
      PH_TYPE   = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_ADR_HI = 3'd3,
      PH_ADR_LO = 3'd4,
      PH_DATA   = 3'd5,
      PH_DONE   = 3'd6,
      PH_FAIL   = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_END   = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_TYPE  = 3'd1,
      ERR_CHUNK_HDR = 3'd2,
      ERR_BAD_END   = 3'd3,
      ERR_EARLY_END = 3'd4
   } err_type;

   // Input item as held in the input register
   typedef struct packed {
      byte_type byte_value;
      logic     end_of_input;
   } req_type;

   // Result item as produced by the parser core
   typedef struct packed {
      kind_type result_kind;
      addr_type write_address;
      byte_type write_data;
      err_type  error_code;
      addr_type lowest_address;
      addr_type highest_address;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/bslp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment loader parser channels
// Valid/ready channels for image bytes and for parser results.
// ----------------------------------------------------------------------------
interface bslp_req_if;
   logic                valid;
   logic                ready;
   bslp_pkg::byte_type  byte_value;
   logic                end_of_input;

   modport source (output valid, output byte_value, output end_of_input, input ready);
   modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface bslp_rsp_if;
   logic                valid;
   logic                ready;
   bslp_pkg::kind_type  result_kind;
   bslp_pkg::addr_type  write_address;
   bslp_pkg::byte_type  write_data;
   bslp_pkg::err_type   error_code;
   bslp_pkg::addr_type  lowest_address;
   bslp_pkg::addr_type  highest_address;

   modport source (output valid, output result_kind, output write_address,
                   output write_data, output error_code, output lowest_address,
                   output highest_address, input ready);
   modport sink   (input valid, input result_kind, input write_address,
                   input write_data, input error_code, input lowest_address,
                   input highest_address, output ready);
endinterface
`default_nettype wire

// ===== sv/bslp_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment loader parser input register
// Registers one incoming item and hands it on when the core advances.
// ----------------------------------------------------------------------------
module bslp_in_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   bslp_req_if.sink              req,
   input  wire logic             advance,
   output logic                  item_valid,
   output bslp_pkg::req_type     item
);

   logic              valid_ff;
   logic              valid_in;
   bslp_pkg::req_type item_ff;
   logic              take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.byte_value   <= req.byte_value;
         item_ff.end_of_input <= req.end_of_input;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// ===== sv/bslp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment loader parser core
// Segment state machine, address arithmetic and low/high address marks.
// ----------------------------------------------------------------------------
module bslp_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire bslp_pkg::req_type item,
   output bslp_pkg::rsp_type      result
);

   bslp_pkg::phase_type phase_ff, phase_in;
   logic                is_end_ff, is_end_in;
   bslp_pkg::len_type   seg_len_ff, seg_len_in;
   bslp_pkg::addr_type  seg_addr_ff, seg_addr_in;
   bslp_pkg::len_type   done_ff, done_in;
   bslp_pkg::addr_type  low_ff, low_in;
   bslp_pkg::addr_type  high_ff, high_in;
   bslp_pkg::err_type   err_ff, err_in;

   bslp_pkg::byte_type  b;
   logic                eoi;
   bslp_pkg::addr_type  waddr;
   bslp_pkg::len_type   done_inc;
   bslp_pkg::len_type   len_shift;
   bslp_pkg::addr_type  addr_shift;
   logic                good_type;

   assign b          = item.byte_value;
   assign eoi        = item.end_of_input;
   assign waddr      = seg_addr_ff + bslp_pkg::addr_type'(done_ff);
   assign done_inc   = done_ff + bslp_pkg::len_type'(1);
   assign len_shift  = {seg_len_ff[bslp_pkg::LenBits-9:0], b};
   assign addr_shift = {seg_addr_ff[bslp_pkg::AddrBits-9:0], b};
   assign good_type  = (b == bslp_pkg::TypeData) || (b == bslp_pkg::TypeEnd);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         bslp_pkg::PH_TYPE: begin
            phase_in = (!eoi && good_type) ? bslp_pkg::PH_LEN_HI : bslp_pkg::PH_FAIL;
         end
         bslp_pkg::PH_LEN_HI: begin
            phase_in = eoi ? bslp_pkg::PH_FAIL : bslp_pkg::PH_LEN_LO;
         end
         bslp_pkg::PH_LEN_LO: begin
            phase_in = eoi ? bslp_pkg::PH_FAIL : bslp_pkg::PH_ADR_HI;
         end
         bslp_pkg::PH_ADR_HI: begin
            phase_in = eoi ? bslp_pkg::PH_FAIL : bslp_pkg::PH_ADR_LO;
         end
         bslp_pkg::PH_ADR_LO: begin
            if (eoi) begin
               phase_in = bslp_pkg::PH_FAIL;
            end else if (is_end_ff) begin
               phase_in = (seg_len_ff != '0) ? bslp_pkg::PH_FAIL : bslp_pkg::PH_DONE;
            end else begin
               phase_in = (seg_len_ff == '0) ? bslp_pkg::PH_TYPE : bslp_pkg::PH_DATA;
            end
         end
         bslp_pkg::PH_DATA: begin
            if (eoi) begin
               phase_in = bslp_pkg::PH_FAIL;
            end else if (done_inc == seg_len_ff) begin
               phase_in = bslp_pkg::PH_TYPE;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Datapath and result
   always_comb begin
      is_end_in   = is_end_ff;
      seg_len_in  = seg_len_ff;
      seg_addr_in = seg_addr_ff;
      done_in     = done_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      err_in      = err_ff;

      result.result_kind   = bslp_pkg::KIND_NONE;
      result.write_address = '0;
      result.write_data    = '0;

      case (phase_ff)
         bslp_pkg::PH_TYPE: begin
            if (!eoi && good_type) begin
               is_end_in   = (b == bslp_pkg::TypeEnd);
               seg_len_in  = '0;
               seg_addr_in = '0;
               done_in     = '0;
            end else begin
               err_in             = bslp_pkg::ERR_BAD_TYPE;
               result.result_kind = bslp_pkg::KIND_ERROR;
            end
         end
         bslp_pkg::PH_LEN_HI, bslp_pkg::PH_LEN_LO, bslp_pkg::PH_ADR_HI: begin
            if (eoi) begin
               err_in = is_end_ff ? bslp_pkg::ERR_BAD_END : bslp_pkg::ERR_CHUNK_HDR;
               result.result_kind = bslp_pkg::KIND_ERROR;
            end else if (phase_ff == bslp_pkg::PH_ADR_HI) begin
               seg_addr_in = addr_shift;
            end else begin
               seg_len_in = len_shift;
            end
         end
         bslp_pkg::PH_ADR_LO: begin
            if (eoi) begin
               err_in = is_end_ff ? bslp_pkg::ERR_BAD_END : bslp_pkg::ERR_CHUNK_HDR;
               result.result_kind = bslp_pkg::KIND_ERROR;
            end else begin
               seg_addr_in = addr_shift;
               if (is_end_ff) begin
                  if (seg_len_ff != '0) begin
                     err_in             = bslp_pkg::ERR_BAD_END;
                     result.result_kind = bslp_pkg::KIND_ERROR;
                  end else begin
                     result.result_kind = bslp_pkg::KIND_END;
                  end
               end
            end
         end
         bslp_pkg::PH_DATA: begin
            if (eoi) begin
               err_in             = bslp_pkg::ERR_EARLY_END;
               result.result_kind = bslp_pkg::KIND_ERROR;
            end else begin
               result.result_kind   = bslp_pkg::KIND_WRITE;
               result.write_address = waddr;
               result.write_data    = b;
               done_in              = done_inc;
               if (waddr < low_ff) begin
                  low_in = waddr;
               end
               if (waddr > high_ff) begin
                  high_in = waddr;
               end
            end
         end
         default: begin
            // done or failed: hold everything
            result.result_kind = bslp_pkg::KIND_NONE;
         end
      endcase

      result.error_code      = err_in;
      result.lowest_address  = low_in;
      result.highest_address = high_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= bslp_pkg::PH_TYPE;
         is_end_ff   <= 1'b0;
         seg_len_ff  <= '0;
         seg_addr_ff <= '0;
         done_ff     <= '0;
         low_ff      <= '1;
         high_ff     <= '0;
         err_ff      <= bslp_pkg::ERR_NONE;
      end else if (step) begin
         phase_ff    <= phase_in;
         is_end_ff   <= is_end_in;
         seg_len_ff  <= seg_len_in;
         seg_addr_ff <= seg_addr_in;
         done_ff     <= done_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         err_ff      <= err_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/bslp_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Segment loader parser result register
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module bslp_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire bslp_pkg::rsp_type result,
   output logic                   can_load,
   bslp_rsp_if.source             rsp
);

   logic              valid_ff;
   logic              valid_in;
   bslp_pkg::rsp_type data_ff;

   assign can_load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.result_kind     = data_ff.result_kind;
   assign rsp.write_address   = data_ff.write_address;
   assign rsp.write_data      = data_ff.write_data;
   assign rsp.error_code      = data_ff.error_code;
   assign rsp.lowest_address  = data_ff.lowest_address;
   assign rsp.highest_address = data_ff.highest_address;

endmodule
`default_nettype wire

// ===== sv/binary_segment_loader_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Binary segment loader parser
// Turns a segmented binary image, one byte per item, into memory writes.
// ----------------------------------------------------------------------------
// Every accepted byte item yields exactly one result item, which shows up on
// the result channel once it has passed through both registers: the byte is
// captured in an input register, the segment state machine acts on it, and
// the result lands in an output register. One item is accepted per cycle as
// long as the result side keeps taking items. While a result waits untaken,
// the input register takes at most one more byte, then the input stalls until
// the result is taken. After an end segment or the first error the parser
// answers every further item with kind "nothing" and keeps showing the
// sticky error code.
module binary_segment_loader_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   bslp_req_if.sink   req,
   bslp_rsp_if.source rsp
);

   logic              item_valid;
   bslp_pkg::req_type item;
   bslp_pkg::rsp_type result;
   logic              can_load;
   logic              step;

   // advance the held item into the core when the result slot is free
   assign step = item_valid && can_load;

   bslp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .advance    (step),
      .item_valid (item_valid),
      .item       (item)
   );

   bslp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .result (result)
   );

   bslp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .result   (result),
      .can_load (can_load),
      .rsp      (rsp)
   );

endmodule
`default_nettype wire
